// ----- hdl/wam_pkg.sv -----
// Shared types and fixed constants of the Wilson-weighted mean block.
// No dependencies; the top level and the bench import this package.
package wam_pkg;

   localparam int SUM_W  = 30;
   localparam int CNT_W  = 20;
   localparam int MEAN_W = 19;
   localparam int MAG_W  = 18;
   localparam int Z_W    = 16;
   localparam int W_W    = 17;

   localparam logic [MEAN_W-1:0] HALF_Q16 = 19'd131072;
   localparam logic [MEAN_W-1:0] FOUR_Q16 = 19'd262144;
   localparam logic [W_W-1:0]    ONE_Q16  = 17'd65536;
   localparam logic [Z_W-1:0]    Z_RESET  = 16'd32113;

   typedef struct packed {
      logic [SUM_W-1:0] score_sum;
      logic [CNT_W-1:0] review_count;
      logic [CNT_W-1:0] positive_count;
      logic [CNT_W-1:0] negative_count;
   } req_payload_type;

   typedef struct packed {
      logic [MEAN_W-1:0] adjusted_mean;
      logic              empty_word;
   } rsp_payload_type;

endpackage

// ----- hdl/wam_chan_if.sv -----
// Valid/ready channel carrying one word of a chosen payload type.
// Payload types come from wam_pkg at instantiation.
interface wam_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/wam_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Caller guarantees dividend < divisor * 2^QW. Uses nothing from wam_pkg.
module wam_div #(
   parameter int DW = 38,
   parameter int VW = 20,
   parameter int QW = 38,
   parameter int XW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [DW-1:0] in_dividend,
   input  logic [VW-1:0] in_divisor,
   input  logic [XW-1:0] in_side,
   output logic          out_vld,
   output logic [QW-1:0] out_quot,
   output logic [XW-1:0] out_side
);
   localparam int HW = DW - QW;

   logic          vld_ff  [QW];
   logic [VW-1:0] rem_ff  [QW];
   logic [QW-1:0] qr_ff   [QW];
   logic [VW-1:0] dvs_ff  [QW];
   logic [XW-1:0] side_ff [QW];
   logic [VW-1:0] init_rem;

   generate
      if (HW == 0) begin : g_nohead
         assign init_rem = '0;
      end else begin : g_head
         assign init_rem = VW'(in_dividend[DW-1:QW]);
      end
   endgenerate

   for (genvar j = 0; j < QW; j++) begin : g_stage
      logic          s_vld;
      logic [VW-1:0] s_rem;
      logic [QW-1:0] s_qr;
      logic [VW-1:0] s_dvs;
      logic [XW-1:0] s_side;
      logic [VW:0]   trial;
      logic          ge;

      if (j == 0) begin : g_first
         assign s_vld  = in_vld;
         assign s_rem  = init_rem;
         assign s_qr   = in_dividend[QW-1:0];
         assign s_dvs  = in_divisor;
         assign s_side = in_side;
      end else begin : g_next
         assign s_vld  = vld_ff[j-1];
         assign s_rem  = rem_ff[j-1];
         assign s_qr   = qr_ff[j-1];
         assign s_dvs  = dvs_ff[j-1];
         assign s_side = side_ff[j-1];
      end

      // shift the next dividend bit in, subtract when it fits
      assign trial = {s_rem, s_qr[QW-1]};
      assign ge    = trial >= {1'b0, s_dvs};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= s_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= ge ? VW'(trial - {1'b0, s_dvs}) : trial[VW-1:0];
            qr_ff[j]   <= {s_qr[QW-2:0], ge};
            dvs_ff[j]  <= s_dvs;
            side_ff[j] <= s_side;
         end
      end
   end

   assign out_vld  = vld_ff[QW-1];
   assign out_quot = qr_ff[QW-1];
   assign out_side = side_ff[QW-1];

endmodule

// ----- hdl/wam_sqrt.sv -----
// Pipelined integer square root (floor), one root bit per stage, with side data.
// Uses nothing from wam_pkg.
module wam_sqrt #(
   parameter int AW = 49,
   parameter int XW = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  logic [AW-1:0]       in_rad,
   input  logic [XW-1:0]       in_side,
   output logic                out_vld,
   output logic [(AW+1)/2-1:0] out_root,
   output logic [XW-1:0]       out_side
);
   localparam int RW = (AW + 1) / 2;

   logic            vld_ff  [RW];
   logic [RW:0]     rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [2*RW-1:0] rad_ff  [RW];
   logic [XW-1:0]   side_ff [RW];

   for (genvar j = 0; j < RW; j++) begin : g_stage
      logic            s_vld;
      logic [RW:0]     s_rem;
      logic [RW-1:0]   s_root;
      logic [2*RW-1:0] s_rad;
      logic [XW-1:0]   s_side;
      logic [RW+2:0]   trial;
      logic [RW+2:0]   test;
      logic            ge;

      if (j == 0) begin : g_first
         assign s_vld  = in_vld;
         assign s_rem  = '0;
         assign s_root = '0;
         assign s_rad  = (2*RW)'(in_rad);
         assign s_side = in_side;
      end else begin : g_next
         assign s_vld  = vld_ff[j-1];
         assign s_rem  = rem_ff[j-1];
         assign s_root = root_ff[j-1];
         assign s_rad  = rad_ff[j-1];
         assign s_side = side_ff[j-1];
      end

      // bring down two radicand bits, try root*4+1
      assign trial = {s_rem, s_rad[2*RW-1 -: 2]};
      assign test  = {1'b0, s_root, 2'b01};
      assign ge    = trial >= test;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= s_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= ge ? (RW+1)'(trial - test) : trial[RW:0];
            root_ff[j] <= {s_root[RW-2:0], ge};
            rad_ff[j]  <= {s_rad[2*RW-3:0], 2'b00};
            side_ff[j] <= s_side;
         end
      end
   end

   assign out_vld  = vld_ff[RW-1];
   assign out_root = root_ff[RW-1];
   assign out_side = side_ff[RW-1];

endmodule

// ----- hdl/wilson_adjusted_mean_top.sv -----
// Wilson-weighted mean rating: top level with channels, stages and output skid.
// Depends on wam_pkg, wam_chan_if, wam_div and wam_sqrt.
//
// Use: req_ch carries one word's totals (rating sum in Q22.8, review, positive
// and negative counts); rsp_ch returns the mean pulled toward 2.0 by the Wilson
// lower bound of the matching share, in Q3.16, plus an empty flag when the
// count is zero. csr_ch writes confidence_z (Q2.14); it is always ready; the user
// must write it only while no word is in flight, as the block does not enforce this.
// Throughput: one word per cycle while the output register is not full.
// Path: from accept to rsp_ch.valid a word passes the mean divider, the b and c
// registers, the share divider, the d register, the square root, the e and f
// registers, the bound divider, the g register and the output register. The
// dividers and the square root each retire one bit per stage.
// Reset: clears all stage valid bits and the output and skid valid bits, and loads
// confidence_z with 1.96.
// Stall: a two-entry output register holds finished words; the pipeline
// freezes only while both entries are full, and req_ch.ready drops with it.
module wilson_adjusted_mean_top #(
   parameter int COUNT_BITS = 20
) (
   input logic       clock,
   input logic       reset,
   wam_chan_if.sink   req_ch,
   wam_chan_if.source rsp_ch,
   wam_chan_if.sink   csr_ch
);
   import wam_pkg::*;

   localparam int CB   = COUNT_BITS;
   localparam int IW   = (CB < CNT_W) ? CB : CNT_W;
   localparam int D1W  = SUM_W + 8;
   localparam int PRW  = 2 * CB;
   localparam int D2W  = 2 * CB + 30;
   localparam int Q2W  = CB + 28;
   localparam int AW   = CB + 29;
   localparam int RW   = (AW + 1) / 2;
   localparam int ZSW  = Z_W + RW;
   localparam int PW   = CB + 31;
   localparam int D3W  = PW + 16;
   localparam int Q3W  = 16;
   localparam int GW   = MAG_W + W_W;

   typedef struct packed {
      logic [CB-1:0] n;
      logic [CB-1:0] pos;
      logic [CB-1:0] neg;
   } s1_type;

   typedef struct packed {
      logic [CB-1:0]    n;
      logic [CB-1:0]    k;
      logic [MAG_W-1:0] mag;
      logic             below;
      logic             empty;
   } s2_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             below;
      logic             empty;
      logic             sat;
   } s3_type;

   logic en;

   // configuration
   logic [Z_W-1:0]   z_ff;
   logic [2*Z_W-1:0] zz_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         z_ff <= Z_RESET;
      end else if (csr_ch.valid) begin
         z_ff <= csr_ch.payload;
      end
   end

   always_ff @(posedge clock) begin
      zz_ff <= (2*Z_W)'(z_ff) * (2*Z_W)'(z_ff);
   end

   // mean divider: (sum << 8) / n
   s1_type           a_side;
   logic             q1_vld;
   logic [D1W-1:0]   q1;
   s1_type           q1_side;

   assign req_ch.ready = en;
   assign a_side.n     = CB'(req_ch.payload.review_count[IW-1:0]);
   assign a_side.pos   = CB'(req_ch.payload.positive_count[IW-1:0]);
   assign a_side.neg   = CB'(req_ch.payload.negative_count[IW-1:0]);

   wam_div #(.DW(D1W), .VW(CB), .QW(D1W), .XW($bits(s1_type))) u_mean_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_vld     (req_ch.valid),
      .in_dividend({req_ch.payload.score_sum, 8'b0}),
      .in_divisor (a_side.n),
      .in_side    (a_side),
      .out_vld    (q1_vld),
      .out_quot   (q1),
      .out_side   (q1_side)
   );

   // center the mean and pick the share
   logic [MEAN_W-1:0] m_in;
   logic [CB-1:0]     kraw_in;
   s2_type            b_in;
   logic              b_vld_ff;
   s2_type            b_ff;

   always_comb begin
      m_in       = (q1 > D1W'(FOUR_Q16)) ? FOUR_Q16 : q1[MEAN_W-1:0];
      b_in.n     = q1_side.n;
      b_in.below = m_in < HALF_Q16;
      b_in.mag   = b_in.below ? MAG_W'(HALF_Q16 - m_in) : MAG_W'(m_in - HALF_Q16);
      kraw_in    = b_in.below ? q1_side.neg : q1_side.pos;
      b_in.k     = (kraw_in > q1_side.n) ? q1_side.n : kraw_in;
      b_in.empty = q1_side.n == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= q1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff <= b_in;
      end
   end

   // k * (n - k)
   logic           c_vld_ff;
   logic [PRW-1:0] c_prod_ff;
   s2_type         c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_prod_ff <= PRW'(b_ff.k) * PRW'(b_ff.n - b_ff.k);
         c_ff      <= b_ff;
      end
   end

   // share variance: k(n-k) * 2^30 / n
   logic           q2_vld;
   logic [Q2W-1:0] q2;
   s2_type         q2_side;

   wam_div #(.DW(D2W), .VW(CB), .QW(Q2W), .XW($bits(s2_type))) u_var_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_vld     (c_vld_ff),
      .in_dividend({c_prod_ff, 30'b0}),
      .in_divisor (c_ff.n),
      .in_side    (c_ff),
      .out_vld    (q2_vld),
      .out_quot   (q2),
      .out_side   (q2_side)
   );

   // add z^2/4 (Q.30)
   logic          d_vld_ff;
   logic [AW-1:0] d_a_ff;
   s2_type        d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= q2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_a_ff <= AW'(q2) + AW'(zz_ff);
         d_ff   <= q2_side;
      end
   end

   logic          s_vld;
   logic [RW-1:0] s_root;
   s2_type        s_side;

   wam_sqrt #(.AW(AW), .XW($bits(s2_type))) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (d_vld_ff),
      .in_rad  (d_a_ff),
      .in_side (d_ff),
      .out_vld (s_vld),
      .out_root(s_root),
      .out_side(s_side)
   );

   // z * s, and the plus term and denominator of the bound
   logic           e_vld_ff;
   logic [ZSW-1:0] e_zs_ff;
   logic [PW-1:0]  e_plus_ff;
   logic [PW-1:0]  e_den_ff;
   s2_type         e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff <= s_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_zs_ff   <= ZSW'(z_ff) * ZSW'(s_root);
         e_plus_ff <= (PW'(s_side.k) << 30) + (PW'(zz_ff) << 1);
         e_den_ff  <= (PW'(s_side.n) << 30) + (PW'(zz_ff) << 2);
         e_ff      <= s_side;
      end
   end

   // numerator clamped at zero; flag a bound at or above one
   logic [PW-1:0] minus_in;
   logic [PW-1:0] num_in;
   s3_type        f_in;
   logic          f_vld_ff;
   logic [PW-1:0] f_num_ff;
   logic [PW-1:0] f_den_ff;
   s3_type        f_ff;

   always_comb begin
      minus_in   = PW'(e_zs_ff) << 1;
      num_in     = (e_plus_ff > minus_in) ? e_plus_ff - minus_in : '0;
      f_in.mag   = e_ff.mag;
      f_in.below = e_ff.below;
      f_in.empty = e_ff.empty;
      f_in.sat   = num_in >= e_den_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (en) begin
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_num_ff <= num_in;
         f_den_ff <= e_den_ff;
         f_ff     <= f_in;
      end
   end

   // bound w = num * 2^16 / den
   logic           q3_vld;
   logic [Q3W-1:0] q3;
   s3_type         q3_side;

   wam_div #(.DW(D3W), .VW(PW), .QW(Q3W), .XW($bits(s3_type))) u_bound_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_vld     (f_vld_ff),
      .in_dividend({f_num_ff, 16'b0}),
      .in_divisor (f_den_ff),
      .in_side    (f_ff),
      .out_vld    (q3_vld),
      .out_quot   (q3),
      .out_side   (q3_side)
   );

   // scale the centered mean by w
   logic [W_W-1:0] w_in;
   logic           g_vld_ff;
   logic [GW-1:0]  g_prod_ff;
   s3_type         g_ff;

   assign w_in = q3_side.sat ? ONE_Q16 : W_W'(q3);

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (en) begin
         g_vld_ff <= q3_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_prod_ff <= GW'(q3_side.mag) * GW'(w_in);
         g_ff      <= q3_side;
      end
   end

   // final add and two-entry output register
   logic [MEAN_W-1:0] part;
   rsp_payload_type   word_in;
   logic              leave;
   logic              take;
   logic              out_vld_ff;
   logic              out_vld_in;
   rsp_payload_type   out_ff;
   rsp_payload_type   out_in;
   logic              skid_vld_ff;
   logic              skid_vld_in;
   rsp_payload_type   skid_ff;
   rsp_payload_type   skid_in;

   assign part = g_prod_ff[16 +: MEAN_W];

   always_comb begin
      word_in.empty_word = g_ff.empty;
      priority if (g_ff.empty) begin
         word_in.adjusted_mean = HALF_Q16;
      end else if (g_ff.below) begin
         word_in.adjusted_mean = HALF_Q16 - part;
      end else begin
         word_in.adjusted_mean = HALF_Q16 + part;
      end
   end

   assign en    = !skid_vld_ff;
   assign leave = en && g_vld_ff;
   assign take  = out_vld_ff && rsp_ch.ready;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      priority if (skid_vld_ff) begin
         // pipeline frozen; drain the skid into the output
         if (take) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (leave) begin
         if (!out_vld_ff || take) begin
            out_in     = word_in;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = word_in;
            skid_vld_in = 1'b1;
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid   = out_vld_ff;
   assign rsp_ch.payload = out_ff;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds a word while output register is empty");

   assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.empty_word) |-> (out_ff.adjusted_mean == HALF_Q16))
      else $error("empty word does not give 2.0");

   assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_ff.adjusted_mean <= FOUR_Q16))
      else $error("adjusted mean above 4.0");

endmodule

// ----- verif/wilson_adjusted_mean_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for wilson_adjusted_mean_top: random and directed rating totals
// against a bit-exact Wilson-bound predictor, across several confidence_z settings.
// Depends on wam_pkg, wam_chan_if and the block's RTL.
module wilson_adjusted_mean_top_tb;
   import wam_pkg::*;

   localparam int LATENCY     = 134;
   localparam int WATCH_LIMIT = 20000;
   localparam int LONG_HOLD   = 600;

   logic clock;
   logic reset;

   wam_chan_if #(.payload_type(req_payload_type)) req_if ();
   wam_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();
   wam_chan_if #(.payload_type(logic [Z_W-1:0]))  csr_if ();

   wilson_adjusted_mean_top #(.COUNT_BITS(CNT_W)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source),
      .csr_ch (csr_if.sink)
   );

   req_payload_type pending_words[$];
   rsp_payload_type expected_means[$];
   logic [Z_W-1:0]  z_model;
   logic            req_took;
   logic            send_pause;
   int              mismatches;
   int              rsp_seen;
   int              idle_cycles;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = 0;
      for (int i = 31; i >= 0; i--) begin
         trial = root | (64'd1 << i);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   // Wilson lower bound of k out of n in Q.16, n nonzero, k at most n
   function automatic logic [63:0] wilson_bound(logic [63:0] k, logic [63:0] n,
                                                logic [63:0] z);
      logic [63:0] prod, zz, a30, s, plus, minus, num, den;
      logic [79:0] wide;
      prod  = k * (n - k);
      zz    = z * z;
      a30   = ((prod / n) << 30) + (((prod % n) << 30) / n) + zz;
      s     = isqrt(a30);
      plus  = (k << 30) + 2 * zz;
      minus = 2 * z * s;
      num   = (plus > minus) ? plus - minus : 0;
      den   = (n << 30) + 4 * zz;
      if (num >= den) return 64'd65536;
      wide = {16'd0, num} << 16;
      return 64'(wide / den);
   endfunction

   function automatic rsp_payload_type predict_mean(req_payload_type w, logic [Z_W-1:0] z);
      rsp_payload_type r;
      logic [63:0] n, m, mag, k, part;
      logic        below;
      n = w.review_count;
      r.empty_word = (n == 0);
      if (n == 0) begin
         r.adjusted_mean = HALF_Q16;
         return r;
      end
      m = ({34'd0, w.score_sum} << 8) / n;
      if (m > FOUR_Q16) m = FOUR_Q16;
      below = m < HALF_Q16;
      mag   = below ? HALF_Q16 - m : m - HALF_Q16;
      k     = below ? w.negative_count : w.positive_count;
      if (k > n) k = n;
      part  = (mag * wilson_bound(k, n, z)) >> 16;
      r.adjusted_mean = MEAN_W'(below ? HALF_Q16 - part : HALF_Q16 + part);
      return r;
   endfunction

   // driver: bursts of words with random gaps
   int burst_left = 5;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_words.size() > 0 && !send_pause) begin
            req_if.payload <= pending_words.pop_front();
            req_if.valid   <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               case ($urandom_range(0, 3))
                  0: gap_left = 0;
                  1: gap_left = $urandom_range(1, 3);
                  2: gap_left = $urandom_range(1, 12);
                  default: gap_left = 1;
               endcase
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver: own stall pattern, plus one long hold to fill the pipeline
   int hold_cnt = 0;
   int mode_cnt = 0;
   int rx_mode = 0;
   bit held_once = 0;
   always @(negedge clock) begin
      if (!held_once && rsp_seen >= 100) begin
         held_once = 1;
         hold_cnt  = LONG_HOLD;
      end
      if (mode_cnt == 0) begin
         mode_cnt = $urandom_range(16, 96);
         rx_mode  = $urandom_range(0, 2);
      end
      mode_cnt--;
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_if.ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // monitor: predict on accept, check on result
   always @(posedge clock) begin
      rsp_payload_type want;
      req_took <= req_if.valid && req_if.ready;
      if (reset) begin
         z_model <= Z_RESET;
      end else begin
         if (csr_if.valid && csr_if.ready) z_model <= csr_if.payload;
         if (req_if.valid && req_if.ready)
            expected_means.insert(expected_means.size(),
                                  predict_mean(req_if.payload, z_model));
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_seen++;
            if (expected_means.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: mean=%0d empty=%0d",
                           rsp_if.payload.adjusted_mean, rsp_if.payload.empty_word);
            end else begin
               want = expected_means.pop_front();
               if (want.adjusted_mean !== rsp_if.payload.adjusted_mean ||
                   want.empty_word !== rsp_if.payload.empty_word) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: mean exp %0d got %0d, empty exp %0d got %0d",
                              want.adjusted_mean, rsp_if.payload.adjusted_mean,
                              want.empty_word, rsp_if.payload.empty_word);
               end
            end
         end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic req_payload_type make_word(logic [29:0] sum, logic [19:0] n,
                                                 logic [19:0] pos, logic [19:0] neg);
      req_payload_type w;
      w.score_sum      = sum;
      w.review_count   = n;
      w.positive_count = pos;
      w.negative_count = neg;
      return w;
   endfunction

   task automatic add_pending(req_payload_type w);
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic queue_directed();
      add_pending(make_word(30'h3FFFFFFF, 20'd0, 20'd5, 20'd7));   // empty word
      add_pending(make_word(30'd0, 20'd0, 20'd0, 20'd0));
      add_pending(make_word(30'd0, 20'd1, 20'd0, 20'd1));          // lowest mean
      add_pending(make_word(30'd0, 20'd1, 20'd1, 20'd0));
      add_pending(make_word(30'd1024, 20'd1, 20'd1, 20'd0));       // 4.0
      add_pending(make_word(30'h3FFFFFFF, 20'd1, 20'd1, 20'd1));   // mean saturates
      add_pending(make_word(30'h3FFFFFFF, 20'd3, 20'hFFFFF, 20'd0)); // share > n
      add_pending(make_word(30'd0, 20'd9, 20'd0, 20'hFFFFF));
      add_pending(make_word(30'd5120, 20'd10, 20'd10, 20'd0));     // centered zero
      add_pending(make_word(30'd512000, 20'd1000, 20'd0, 20'd1000));
      add_pending(make_word(30'h3FFFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF));
      add_pending(make_word(30'd0, 20'hFFFFF, 20'd0, 20'hFFFFF));
      add_pending(make_word(30'd1024 * 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'd0));
      add_pending(make_word(30'd511, 20'd1, 20'd0, 20'd0));        // k zero
      add_pending(make_word(30'd513, 20'd1, 20'd0, 20'd0));
      add_pending(make_word(30'd700, 20'd2, 20'd1, 20'd1));
   endtask

   task automatic queue_random(int count);
      logic [19:0] n;
      logic [29:0] sum;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            // noise: every bit of every field free
            add_pending(make_word(30'($urandom), 20'($urandom), 20'($urandom),
                                  20'($urandom)));
         end else begin
            case ($urandom_range(0, 3))
               0: n = 20'($urandom_range(1, 8));
               1: n = 20'($urandom_range(1, 300));
               2: n = 20'($urandom_range(1, 60000));
               default: n = 20'($urandom_range(1, 20'hFFFFF));
            endcase
            sum = 30'(64'(n) * $urandom_range(0, 1024) + $urandom_range(0, 255));
            add_pending(make_word(sum, n, 20'($urandom_range(0, n)),
                                  20'($urandom_range(0, n))));
         end
      end
   endtask

   task automatic wait_idle();
      while (pending_words.size() > 0 || req_if.valid || expected_means.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 16) @(posedge clock);
   endtask

   task automatic write_z(logic [Z_W-1:0] z);
      @(negedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.payload <= z;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   logic [Z_W-1:0] z_plan[6];

   initial begin
      reset          = 1'b1;
      send_pause     = 1'b0;
      mismatches     = 0;
      rsp_seen       = 0;
      idle_cycles    = 0;
      req_took       = 1'b0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      z_plan = '{Z_RESET, 16'd0, 16'hFFFF, 16'd16384, 16'd1, 16'd32113};
      z_plan[4] = 16'($urandom);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0) write_z(z_plan[phase]);
         if (phase < 3) queue_directed();
         queue_random(phase == 1 ? 220 : 70);
         // wait until the block has drained before the next phase
         wait_idle();
      end

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
